@@ rtl/core/ang_pkg.sv @@
package ang_pkg;

	typedef struct packed {
		logic signed [15:0] left_in;
		logic signed [15:0] right_in;
	} ang_in_t;

	typedef struct packed {
		logic signed [15:0] left_out;
		logic signed [15:0] right_out;
		logic               subframe_first;
		logic               gate_open;
		logic               pulse_seen;
		logic               peak_passed;
	} ang_out_t;

	// gain ramp applied to the emitted subframe
	typedef enum logic [1:0] {
		MODE_MUTE,
		MODE_UNITY,
		MODE_UP,
		MODE_DOWN
	} ang_mode_t;

	// register index, taken from paddr[2]
	localparam logic REG_GATE_RATIO       = 1'b0;
	localparam logic REG_WINDOW_SUBFRAMES = 1'b1;

	localparam logic [15:0] GATE_RATIO_RST       = 16'd512;
	localparam logic [6:0]  WINDOW_SUBFRAMES_RST = 7'd16;

	localparam logic [15:0] GAIN_UNITY = 16'h8000;
	localparam logic [15:0] FLOOR_ONE  = 16'h8000;

endpackage

@@ rtl/core/adaptive_noise_gate_core.sv @@
// Adaptive noise gate. Stereo Q1.15 frames are grouped into subframes of
// SUBFRAME_FRAMES frames; the peak magnitude of each subframe is compared
// against gate_ratio (Q8.8) times the mean of the last
// window_subframes peaks (1.0 until a peak is recorded), and the subframe is
// replayed one subframe later from an internal delay memory with a per-frame
// linear gain ramp set by the decision. The first subframe out after reset
// is all zero. Throughput is one frame per clock unless gated_stall holds the
// result register; the delay memory is read at accept and written when the
// frame leaves the input register, at a different slot, so the input stalls
// only when the input register is occupied while the result register is held
// by gated_stall. A result passes through the input register, then the result
// register, carrying the audio of the frame SUBFRAME_FRAMES positions earlier.
// There is no clearing pass after reset.
// Registers: gate_ratio at 0x0, window_subframes at 0x4.
module adaptive_noise_gate_core
	import ang_pkg::*;
#(
	parameter int SUBFRAME_FRAMES = 32,
	parameter int WINDOW_MAX      = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            sample_valid,
	output logic            sample_stall,
	input  ang_in_t         sample,
	output logic            gated_valid,
	input  logic            gated_stall,
	output ang_out_t        gated,
	input  logic            psel,
	input  logic            penable,
	input  logic            pwrite,
	input  logic [2:0]      paddr,
	input  logic [31:0]     pwdata,
	output logic [31:0]     prdata,
	output logic            pready
);

	localparam int POS_W     = $clog2(SUBFRAME_FRAMES);
	localparam int RAMP_STEP = 32768 / SUBFRAME_FRAMES;
	localparam int RAMP_REM  = 32768 % SUBFRAME_FRAMES;
	localparam int WIN_AW    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int CNT_W     = $clog2(WINDOW_MAX + 1);
	localparam int SUM_W     = $clog2(WINDOW_MAX * 32768 + 1);
	localparam int EFF_W     = (CNT_W > 7) ? CNT_W : 7;
	localparam int OLD_W     = WIN_AW + 2;
	localparam int RHS_W     = 16 + SUM_W;
	localparam int LHS_W     = 16 + CNT_W + 8;
	localparam int CMP_W     = (RHS_W > LHS_W) ? RHS_W : LHS_W;

	// configuration
	logic [15:0] gate_ratio_q;
	logic [6:0]  window_subframes_q;

	// accept side position and ramp accumulator
	logic [POS_W-1:0] pos_q;
	logic [15:0]      ramp_q;
	logic [POS_W:0]   ramp_rem_q;

	// input stage
	logic             valid_s1;
	ang_in_t          sample_s1;
	logic [POS_W-1:0] pos_s1;
	logic [15:0]      ramp_s1;
	logic [31:0]      delay_rd_s1;

	// subframe and window state
	logic [15:0]      running_peak_q;
	logic [15:0]      previous_peak_q;
	logic             gate_is_open_q;
	logic [WIN_AW-1:0] window_head_q;
	logic [CNT_W-1:0] window_count_q;
	logic [SUM_W-1:0] window_sum_q;
	logic [15:0]      window_oldest_q;
	logic [RHS_W-1:0] rhs_q;
	ang_mode_t        ramp_mode_q;
	logic             flag_open_q;
	logic             flag_pulse_q;
	logic             flag_peak_q;

	// result register
	logic             out_valid_q;
	ang_out_t         out_q;

	logic [31:0] delay_mem [SUBFRAME_FRAMES];
	logic [15:0] window_mem [WINDOW_MAX];

	logic             accept;
	logic             s1_adv;
	logic             s1_fire;
	logic             last_frame;
	logic             cfg_wr;
	logic [15:0]      mag_l;
	logic [15:0]      mag_r;
	logic [15:0]      peak_now;
	logic [CNT_W-1:0] cnt_eff;
	logic [LHS_W-1:0] lhs;
	logic             pulse;
	logic [EFF_W-1:0] eff_window;
	logic             drop_oldest;
	logic [SUM_W:0]   sum_next;
	logic [OLD_W-1:0] oldest_raw;
	logic [WIN_AW-1:0] oldest_idx;
	logic [SUM_W-1:0] floor_sum;
	logic [15:0]      gain;
	logic signed [32:0] prod_l;
	logic signed [32:0] prod_r;
	logic [POS_W:0]   rem_sum;
	ang_mode_t        mode_next;
	logic             gate_next;

	function automatic logic [15:0] magnitude(input logic signed [15:0] s);
		logic [15:0] m;
		m = s[15] ? 16'(-s) : 16'(s);
		return m;
	endfunction

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;

	assign s1_adv       = !out_valid_q || !gated_stall;
	assign sample_stall = valid_s1 && !s1_adv;
	assign accept       = sample_valid && !sample_stall;
	assign s1_fire      = valid_s1 && s1_adv;
	assign last_frame   = (pos_s1 == POS_W'(SUBFRAME_FRAMES - 1));

	assign gated_valid = out_valid_q;
	assign gated       = out_q;

	always_comb begin
		case (paddr[2])
			REG_GATE_RATIO:       prdata = {16'd0, gate_ratio_q};
			REG_WINDOW_SUBFRAMES: prdata = {25'd0, window_subframes_q};
			default:              prdata = 32'd0;
		endcase
	end

	// peak and threshold test
	always_comb begin
		mag_l    = magnitude(sample_s1.left_in);
		mag_r    = magnitude(sample_s1.right_in);
		peak_now = running_peak_q;
		if (mag_l > peak_now) begin
			peak_now = mag_l;
		end
		if (mag_r > peak_now) begin
			peak_now = mag_r;
		end
		cnt_eff = (window_count_q == '0) ? CNT_W'(1) : window_count_q;
		lhs     = {LHS_W'(peak_now * cnt_eff)} << 8;
		pulse   = CMP_W'(lhs) > CMP_W'(rhs_q);

		if (pulse) begin
			mode_next = gate_is_open_q ? MODE_UNITY : MODE_UP;
			gate_next = 1'b1;
		end else begin
			mode_next = gate_is_open_q ? MODE_DOWN : MODE_MUTE;
			gate_next = 1'b0;
		end

		if (window_subframes_q == 7'd0) begin
			eff_window = EFF_W'(1);
		end else if (EFF_W'(window_subframes_q) > EFF_W'(WINDOW_MAX)) begin
			eff_window = EFF_W'(WINDOW_MAX);
		end else begin
			eff_window = EFF_W'(window_subframes_q);
		end
		drop_oldest = (EFF_W'(window_count_q) + EFF_W'(1)) > eff_window;
		sum_next    = (SUM_W+1)'(window_sum_q) + (SUM_W+1)'(peak_now);
		if (drop_oldest) begin
			sum_next = sum_next - (SUM_W+1)'(window_oldest_q);
		end
	end

	// oldest entry of the window, prefetched while head and count hold
	always_comb begin
		oldest_raw = OLD_W'(window_head_q) + OLD_W'(WINDOW_MAX) - OLD_W'(window_count_q);
		if (oldest_raw >= OLD_W'(WINDOW_MAX)) begin
			oldest_raw = oldest_raw - OLD_W'(WINDOW_MAX);
		end
		oldest_idx = oldest_raw[WIN_AW-1:0];
		floor_sum  = (window_count_q == '0) ? SUM_W'(FLOOR_ONE) : window_sum_q;
	end

	// gain for the delayed frame
	always_comb begin
		case (ramp_mode_q)
			MODE_UNITY: gain = GAIN_UNITY;
			MODE_UP:    gain = ramp_s1;
			MODE_DOWN:  gain = GAIN_UNITY - ramp_s1;
			MODE_MUTE:  gain = 16'd0;
			default:    gain = 16'd0;
		endcase
		prod_l  = $signed(delay_rd_s1[31:16]) * $signed({1'b0, gain});
		prod_r  = $signed(delay_rd_s1[15:0]) * $signed({1'b0, gain});
		rem_sum = ramp_rem_q + (POS_W+1)'(RAMP_REM);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			delay_rd_s1 <= delay_mem[pos_q];
		end
		if (s1_fire) begin
			delay_mem[pos_s1] <= {sample_s1.left_in, sample_s1.right_in};
		end
	end

	always_ff @(posedge clk) begin
		window_oldest_q <= window_mem[oldest_idx];
		if (s1_fire && last_frame) begin
			window_mem[window_head_q] <= peak_now;
		end
	end

	always_ff @(posedge clk) begin
		rhs_q <= RHS_W'(gate_ratio_q * floor_sum);
		if (accept) begin
			sample_s1 <= sample;
			pos_s1    <= pos_q;
			ramp_s1   <= ramp_q;
		end
		if (s1_fire) begin
			// mute is forced to zero so unwritten delay entries never leak
			out_q.left_out       <= (ramp_mode_q == MODE_MUTE) ? 16'sd0 : prod_l[30:15];
			out_q.right_out      <= (ramp_mode_q == MODE_MUTE) ? 16'sd0 : prod_r[30:15];
			out_q.subframe_first <= (pos_s1 == '0);
			out_q.gate_open      <= flag_open_q;
			out_q.pulse_seen     <= flag_pulse_q;
			out_q.peak_passed    <= flag_peak_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_ratio_q       <= GATE_RATIO_RST;
			window_subframes_q <= WINDOW_SUBFRAMES_RST;
			pos_q              <= '0;
			ramp_q             <= '0;
			ramp_rem_q         <= '0;
			valid_s1           <= 1'b0;
			out_valid_q        <= 1'b0;
			running_peak_q     <= '0;
			previous_peak_q    <= '0;
			gate_is_open_q     <= 1'b1;
			window_head_q      <= '0;
			window_count_q     <= '0;
			window_sum_q       <= '0;
			ramp_mode_q        <= MODE_MUTE;
			flag_open_q        <= 1'b1;
			flag_pulse_q       <= 1'b0;
			flag_peak_q        <= 1'b0;
		end else begin
			if (cfg_wr) begin
				case (paddr[2])
					REG_GATE_RATIO:       gate_ratio_q <= pwdata[15:0];
					REG_WINDOW_SUBFRAMES: window_subframes_q <= pwdata[6:0];
					default: ;
				endcase
			end

			if (accept) begin
				if (pos_q == POS_W'(SUBFRAME_FRAMES - 1)) begin
					pos_q      <= '0;
					ramp_q     <= '0;
					ramp_rem_q <= '0;
				end else begin
					pos_q <= pos_q + POS_W'(1);
					// ramp = floor(p * 32768 / SUBFRAME_FRAMES), kept as quotient and remainder
					if (rem_sum >= (POS_W+1)'(SUBFRAME_FRAMES)) begin
						ramp_q     <= ramp_q + 16'(RAMP_STEP + 1);
						ramp_rem_q <= rem_sum - (POS_W+1)'(SUBFRAME_FRAMES);
					end else begin
						ramp_q     <= ramp_q + 16'(RAMP_STEP);
						ramp_rem_q <= rem_sum;
					end
				end
			end

			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= valid_s1;
			end

			if (s1_fire) begin
				if (last_frame) begin
					running_peak_q  <= '0;
					previous_peak_q <= peak_now;
					gate_is_open_q  <= gate_next;
					ramp_mode_q     <= mode_next;
					flag_open_q     <= gate_next;
					flag_pulse_q    <= pulse;
					flag_peak_q     <= pulse && (peak_now < previous_peak_q);
					window_head_q   <= (window_head_q == WIN_AW'(WINDOW_MAX - 1)) ?
						'0 : window_head_q + WIN_AW'(1);
					window_sum_q    <= sum_next[SUM_W-1:0];
					if (!drop_oldest) begin
						window_count_q <= window_count_q + CNT_W'(1);
					end
				end else begin
					running_peak_q <= peak_now;
				end
			end
		end
	end

endmodule

@@ rtl/core/ang_checker.sv @@
module ang_checker
	import ang_pkg::*;
#(
	parameter int SUBFRAME_FRAMES = 32
) (
	input logic     clk,
	input logic     arst_n,
	input logic     gated_valid,
	input logic     gated_stall,
	input ang_out_t gated
);

	localparam int POS_W = $clog2(SUBFRAME_FRAMES);

	logic [POS_W-1:0] out_pos_q;
	logic             out_take;

	assign out_take = gated_valid && !gated_stall;

	// position of the next result transaction within its subframe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_pos_q <= '0;
		end else if (out_take) begin
			out_pos_q <= (out_pos_q == POS_W'(SUBFRAME_FRAMES - 1)) ?
				'0 : out_pos_q + POS_W'(1);
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		gated_valid && gated_stall |=> gated_valid && $stable(gated))
		else $error("stalled result changed or dropped");

	a_first: assert property (@(posedge clk) disable iff (!arst_n)
		out_take |-> (gated.subframe_first == (out_pos_q == '0)))
		else $error("subframe_first out of step with subframe boundary");

	a_peak_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		gated_valid && gated.peak_passed |-> gated.pulse_seen)
		else $error("peak flag without pulse");

	a_pulse_open: assert property (@(posedge clk) disable iff (!arst_n)
		gated_valid && gated.pulse_seen |-> gated.gate_open)
		else $error("pulse seen but gate reported closed");

endmodule

bind adaptive_noise_gate_core ang_checker #(
	.SUBFRAME_FRAMES(SUBFRAME_FRAMES)
) u_ang_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.gated_valid (gated_valid),
	.gated_stall (gated_stall),
	.gated       (gated)
);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
	import ang_pkg::*;

	localparam int SUBFRAME     = 32;
	localparam int WIN_MAX      = 64;
	localparam int NUM_PHASES   = 7;
	localparam int LIMIT_CYCLES = 200000;
	localparam int HOLD_AFTER   = 400;
	localparam int HOLD_CYCLES  = 80;

	typedef enum int {LVL_SILENT, LVL_QUIET, LVL_MID, LVL_LOUD, LVL_NOISE} level_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        sample_valid = 1'b0;
	logic        sample_stall;
	ang_in_t     sample = '0;
	logic        gated_valid;
	logic        gated_stall = 1'b0;
	ang_out_t    gated;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	adaptive_noise_gate_core #(
		.SUBFRAME_FRAMES(SUBFRAME),
		.WINDOW_MAX     (WIN_MAX)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample      (sample),
		.gated_valid (gated_valid),
		.gated_stall (gated_stall),
		.gated       (gated),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// gate model state
	logic [31:0]     dly_mem [SUBFRAME];
	int unsigned     peak_hist [WIN_MAX];
	int unsigned     frame_pos = 0;
	int unsigned     run_peak = 0;
	int unsigned     prev_peak = 0;
	int unsigned     win_head = 0;
	int unsigned     win_count = 0;
	longint unsigned win_sum = 0;
	bit              gate_state = 1'b1;
	ang_mode_t       emit_mode = MODE_MUTE;
	bit              flag_open = 1'b1;
	bit              flag_pulse = 1'b0;
	bit              flag_peak = 1'b0;
	logic [15:0]     cfg_factor = GATE_RATIO_RST;
	logic [6:0]      cfg_window = WINDOW_SUBFRAMES_RST;

	ang_in_t  pending_q [$];
	ang_out_t gated_expect_q [$];
	ang_out_t want_frame;

	bit          in_taken = 1'b0;
	bit          idle_en = 1'b1;
	int          gap_left = 0;
	int          stall_left = 0;
	int          hold_left = 0;
	bit          hold_done = 1'b0;
	int unsigned gated_count = 0;
	int unsigned mismatches = 0;
	int unsigned cfg_errors = 0;
	int unsigned cycles = 0;
	int unsigned gen_pos = 0;
	level_t      gen_level = LVL_NOISE;

	function automatic logic [15:0] apply_q15_gain(logic signed [15:0] s, int unsigned g);
		longint prod;
		prod = longint'(s) * longint'(g);
		return prod[30:15];
	endfunction

	function automatic int unsigned magnitude(logic signed [15:0] s);
		return (s < 0) ? int'(-int'(s)) : int'(s);
	endfunction

	// Emits the delayed frame for this slot, stores the new one, and at the
	// subframe's last frame decides the gate and updates the noise floor.
	function automatic ang_out_t predict_gated_frame(ang_in_t s);
		ang_out_t        o;
		logic [31:0]     held;
		int unsigned     gain, ramp_gain, w, oldest;
		longint unsigned lhs, rhs;
		bit              pulse, pk;
		held = dly_mem[frame_pos];
		ramp_gain = frame_pos * 32768 / SUBFRAME;
		case (emit_mode)
			MODE_UNITY: gain = 32768;
			MODE_UP:    gain = ramp_gain;
			MODE_DOWN:  gain = 32768 - ramp_gain;
			default:    gain = 0;
		endcase
		o.left_out       = apply_q15_gain(held[31:16], gain);
		o.right_out      = apply_q15_gain(held[15:0], gain);
		o.subframe_first = (frame_pos == 0);
		o.gate_open      = flag_open;
		o.pulse_seen     = flag_pulse;
		o.peak_passed    = flag_peak;

		dly_mem[frame_pos] = s;
		if (magnitude(s.left_in) > run_peak)
			run_peak = magnitude(s.left_in);
		if (magnitude(s.right_in) > run_peak)
			run_peak = magnitude(s.right_in);

		if (frame_pos == SUBFRAME - 1) begin
			if (win_count == 0) begin
				lhs = longint'(run_peak) * 256;
				rhs = longint'(cfg_factor) * 32768;
			end else begin
				lhs = longint'(run_peak) * win_count * 256;
				rhs = longint'(cfg_factor) * win_sum;
			end
			pulse = lhs > rhs;
			pk = 1'b0;
			if (pulse) begin
				emit_mode = gate_state ? MODE_UNITY : MODE_UP;
				gate_state = 1'b1;
				pk = run_peak < prev_peak;
			end else begin
				emit_mode = gate_state ? MODE_DOWN : MODE_MUTE;
				gate_state = 1'b0;
			end
			flag_open  = gate_state;
			flag_pulse = pulse;
			flag_peak  = pk;

			// window 0 behaves as 1, oversize clamps to the store depth
			w = (cfg_window == 0) ? 1 : (cfg_window > WIN_MAX) ? WIN_MAX : cfg_window;
			oldest = peak_hist[(win_head + WIN_MAX - win_count) % WIN_MAX];
			peak_hist[win_head] = run_peak;
			win_head = (win_head + 1) % WIN_MAX;
			win_sum += run_peak;
			if (win_count + 1 > w)
				win_sum -= oldest;
			else
				win_count++;
			prev_peak = run_peak;
			run_peak = 0;
			frame_pos = 0;
		end else begin
			frame_pos++;
		end
		return o;
	endfunction

	function automatic logic [15:0] pick_sample(level_t lv);
		int m;
		case (lv)
			LVL_SILENT: m = 0;
			LVL_QUIET:  m = $urandom_range(0, 40);
			LVL_MID:    m = $urandom_range(0, 3000);
			LVL_LOUD:   m = ($urandom_range(0, 7) == 0) ? 32768 : $urandom_range(12000, 32768);
			default:    return 16'($urandom);
		endcase
		if (m == 32768)
			return ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7FFF;
		return ($urandom_range(0, 1) != 0) ? 16'(-m) : 16'(m);
	endfunction

	task automatic push_frame(logic [15:0] l, logic [15:0] r);
		ang_in_t item;
		item.left_in  = l;
		item.right_in = r;
		pending_q.push_back(item);
		gen_pos = (gen_pos + 1) % SUBFRAME;
	endtask

	// each subframe gets one loudness level so the gate actually moves
	task automatic queue_frames(int n);
		int pick;
		for (int i = 0; i < n; i++) begin
			if (gen_pos == 0) begin
				pick = $urandom_range(0, 9);
				gen_level = (pick < 2) ? LVL_SILENT : (pick < 5) ? LVL_QUIET :
					(pick < 7) ? LVL_MID : (pick < 9) ? LVL_LOUD : LVL_NOISE;
			end
			push_frame(pick_sample(gen_level), pick_sample(gen_level));
		end
	endtask

	// checked at the rising edge, where the sender's queue and valid are settled
	task automatic wait_drained();
		while (pending_q.size() != 0 || sample_valid || gated_expect_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic rsel, logic [31:0] value);
		logic [31:0] mask;
		mask = (rsel == REG_GATE_RATIO) ? 32'h0000_FFFF : 32'h0000_007F;
		@(negedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= {rsel, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (rsel == REG_GATE_RATIO)
			cfg_factor = value[15:0];
		else
			cfg_window = value[6:0];
		// read back
		@(negedge clk);
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if ((prdata & mask) != (value & mask)) begin
			cfg_errors++;
			if (cfg_errors <= 10)
				$display("register %0d read back %h, wrote %h", rsel, prdata & mask,
					value & mask);
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// sender
	always @(posedge clk)
		in_taken <= sample_valid && !sample_stall;

	always @(negedge clk) begin
		if (!sample_valid || in_taken) begin
			if (gap_left > 0) begin
				gap_left--;
				sample_valid <= 1'b0;
			end else if (pending_q.size() != 0) begin
				sample       <= pending_q.pop_front();
				sample_valid <= 1'b1;
				if (idle_en && $urandom_range(0, 5) == 0)
					gap_left = $urandom_range(1, 3);
			end else begin
				sample_valid <= 1'b0;
			end
		end
	end

	// receiver: random short stalls plus one long hold-off to back up the pipe
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			gated_stall <= 1'b1;
		end else if (!hold_done && gated_count >= HOLD_AFTER) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES - 1;
			gated_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			gated_stall <= 1'b1;
		end else if (idle_en && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 2);
			gated_stall <= 1'b1;
		end else begin
			gated_stall <= 1'b0;
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (sample_valid && !sample_stall)
				gated_expect_q.push_back(predict_gated_frame(sample));
			if (gated_valid && !gated_stall) begin
				gated_count++;
				if (gated_expect_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("transaction %0d out with nothing expected", gated_count);
				end else begin
					want_frame = gated_expect_q.pop_front();
					if (gated !== want_frame) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("transaction %0d: expected L %0d R %0d first %b open %b pulse %b peak %b",
								gated_count, want_frame.left_out, want_frame.right_out,
								want_frame.subframe_first, want_frame.gate_open,
								want_frame.pulse_seen, want_frame.peak_passed);
							$display("transaction %0d: got L %0d R %0d first %b open %b pulse %b peak %b",
								gated_count, gated.left_out, gated.right_out,
								gated.subframe_first, gated.gate_open,
								gated.pulse_seen, gated.peak_passed);
						end
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		logic [15:0] corner_vals [8];
		int          phase_frames [NUM_PHASES];
		logic [31:0] phase_factor [NUM_PHASES];
		logic [31:0] phase_window [NUM_PHASES];
		corner_vals  = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF,
			16'h0001, 16'h8001, 16'h5555, 16'hAAAA};
		// phase 0 runs on reset values; window 64 is followed by a shrink to 0
		phase_frames = '{200, 317, 130, 96, 101, 190, 384};
		phase_factor = '{512, 300, 384, 0, 65535, 256, 600};
		phase_window = '{16, 64, 0, 1, 127, 2, 8};
		for (int i = 0; i < SUBFRAME; i++)
			dly_mem[i] = '0;
		for (int i = 0; i < WIN_MAX; i++)
			peak_hist[i] = 0;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			if (ph > 0) begin
				wait_drained();
				write_reg(REG_GATE_RATIO, phase_factor[ph]);
				write_reg(REG_WINDOW_SUBFRAMES, phase_window[ph]);
			end
			if (ph == NUM_PHASES - 1)
				idle_en = 1'b0;
			if (ph == 0) begin
				// full-scale, zero, and alternating-bit frames in the first subframe
				for (int i = 0; i < 24; i++)
					push_frame(corner_vals[i % 8], corner_vals[(i * 3 + 1) % 8]);
				queue_frames(phase_frames[ph] - 24);
			end else begin
				queue_frames(phase_frames[ph]);
			end
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && cfg_errors == 0 && gated_expect_q.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
